/* rtl/core/tkslt_pkg.sv */
// ----------------------------------------------------------------------------
// Top-k smallest limit tracker package
// Shared widths, register map codes, reset values and the Q1.16 saturation
// helper used by the tracker, its channel interfaces and its memory.
// ----------------------------------------------------------------------------
package tkslt_pkg;

  // Degree values are unsigned Q1.16 with one integer bit.
  localparam int unsigned DEGREE_W = 17;
  localparam logic [DEGREE_W-1:0] ONE_Q16 = 17'd65536;

  // Width of the result_count register.
  localparam int unsigned RC_W = 7;

  // Default number of heap entries.
  localparam int unsigned MAX_KEPT_DEF = 64;

  // Configuration port widths.
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // Register indexes (byte address divided by four).
  typedef enum logic [1:0] {
    REG_RESULT_COUNT  = 2'd0,
    REG_INITIAL_LIMIT = 2'd1,
    REG_CHANGE_MARGIN = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_t;

  // Register reset values.
  localparam logic [RC_W-1:0]     RESULT_COUNT_RST  = 7'd10;
  localparam logic [DEGREE_W-1:0] INITIAL_LIMIT_RST = 17'd65536;
  localparam logic [DEGREE_W-1:0] CHANGE_MARGIN_RST = 17'd66;

  // Clamp a degree to 1.0.
  function automatic logic [DEGREE_W-1:0] sat_one(input logic [DEGREE_W-1:0] v);
    sat_one = (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

endpackage

/* rtl/core/tkslt_if.sv */
// ----------------------------------------------------------------------------
// Top-k smallest limit tracker channel interfaces
// Valid/ready channels for the incoming degree items and the result items.
// ----------------------------------------------------------------------------

// Input channel: one degree per item.
interface tkslt_in_if
  import tkslt_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [DEGREE_W-1:0] degree;

  modport source (output valid, output degree, input ready);
  modport sink   (input valid, input degree, output ready);
endinterface

// Result channel: limit, change flag and heap fill per item.
interface tkslt_out_if
  import tkslt_pkg::*;
  #(
    parameter int unsigned CNT_W = $clog2(MAX_KEPT_DEF + 1)
  ) ();
  logic                valid;
  logic                ready;
  logic [DEGREE_W-1:0] limit;
  logic                limit_changed;
  logic [CNT_W-1:0]    held_count;

  modport source (output valid, output limit, output limit_changed, output held_count,
                  input ready);
  modport sink   (input valid, input limit, input limit_changed, input held_count,
                  output ready);
endinterface

/* rtl/core/top_k_smallest_limit_tracker_top.sv */
// ----------------------------------------------------------------------------
// Top-k smallest limit tracker
// Keeps the K smallest degrees in a max-heap held in RAM and lowers a running
// limit to the heap top once the heap is full and the top drops far enough.
// ----------------------------------------------------------------------------
// A sift takes a read state and a compare state per heap level moved, then
// the report state; an item that needs no sift goes straight to the report
// state. With K = 64 the heap has seven levels. The sift loop has one read
// of the heap RAM per level. One item is in work at a time; a finished
// result waits in the output register while the next item is taken. Reset
// empties the heap and loads 1.0.
// ----------------------------------------------------------------------------
module top_k_smallest_limit_tracker_top
  import tkslt_pkg::*;
  #(
    parameter int unsigned MAX_KEPT = MAX_KEPT_DEF,
    localparam int unsigned CNT_W   = $clog2(MAX_KEPT + 1),
    localparam int unsigned IDX_W   = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1,
    localparam int unsigned LW      = CNT_W + 1,
    localparam int unsigned KW      = (CNT_W > RC_W) ? CNT_W : RC_W
  ) (
    input  logic                clk,
    input  logic                rst_n,
    // Configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    // Item channels
    tkslt_in_if.sink            in_ch,
    tkslt_out_if.source         out_ch
  );

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_UP_RD  = 6'b000010,
    S_UP_CMP = 6'b000100,
    S_DN_RD  = 6'b001000,
    S_DN_CMP = 6'b010000,
    S_FIN    = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [RC_W-1:0]     rc_r;
  logic [DEGREE_W-1:0] init_r;
  logic [DEGREE_W-1:0] margin_r;
  logic [DEGREE_W-1:0] limit_r, limit_nxt;
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic [IDX_W-1:0]    pos_r, pos_nxt;
  logic [DEGREE_W-1:0] deg_r, deg_nxt;
  logic                mc_r, mc_nxt;
  logic [DEGREE_W-1:0] top_r;
  logic                out_valid_r, out_valid_nxt;
  logic [DEGREE_W-1:0] out_limit_r, out_limit_nxt;
  logic                out_chg_r, out_chg_nxt;
  logic [CNT_W-1:0]    out_cnt_r, out_cnt_nxt;

  logic                cfg_we;
  reg_idx_t            cfg_idx;
  logic                cfg_init_we;
  logic [CNT_W-1:0]    k_cnt;
  logic [DEGREE_W-1:0] in_sat;
  logic [IDX_W-1:0]    parent;
  logic [LW-1:0]       l_ext;
  logic [LW-1:0]       r_ext;
  logic [LW-1:0]       fill_ext;
  logic                r_ok;
  logic                pick_r;
  logic [DEGREE_W-1:0] big_val;
  logic [IDX_W-1:0]    big_idx;
  logic [DEGREE_W:0]   top_plus_margin;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [DEGREE_W-1:0] ram_wdata;
  logic [IDX_W-1:0]    ram_raddr_a;
  logic [IDX_W-1:0]    ram_raddr_b;
  logic [DEGREE_W-1:0] ram_rdata_a;
  logic [DEGREE_W-1:0] ram_rdata_b;

  // Configuration decode; the register index is the word address.
  assign pready      = 1'b1;
  assign cfg_we      = psel && penable && pwrite && pready;
  assign cfg_idx     = reg_idx_t'(paddr[3:2]);
  assign cfg_init_we = cfg_we && (cfg_idx == REG_INITIAL_LIMIT);

  always_comb begin
    unique case (cfg_idx)
      REG_RESULT_COUNT:  prdata = PDATA_W'(rc_r);
      REG_INITIAL_LIMIT: prdata = PDATA_W'(init_r);
      REG_CHANGE_MARGIN: prdata = PDATA_W'(margin_r);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r     <= RESULT_COUNT_RST;
      init_r   <= INITIAL_LIMIT_RST;
      margin_r <= CHANGE_MARGIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_RESULT_COUNT:  rc_r     <= pwdata[RC_W-1:0];
        REG_INITIAL_LIMIT: init_r   <= pwdata[DEGREE_W-1:0];
        REG_CHANGE_MARGIN: margin_r <= pwdata[DEGREE_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective K is clamped to the heap depth.
  assign k_cnt  = (KW'(rc_r) > KW'(MAX_KEPT)) ? CNT_W'(MAX_KEPT) : CNT_W'(rc_r);
  assign in_sat = sat_one(in_ch.degree);

  // Heap index arithmetic for the current position.
  assign parent   = IDX_W'((pos_r - IDX_W'(1)) >> 1);
  assign l_ext    = LW'({pos_r, 1'b1});
  assign r_ext    = l_ext + LW'(1);
  assign fill_ext = LW'(fill_r);

  // Larger child of the two read back from the heap.
  assign r_ok    = r_ext < fill_ext;
  assign pick_r  = r_ok && (ram_rdata_b > ram_rdata_a);
  assign big_val = pick_r ? ram_rdata_b : ram_rdata_a;
  assign big_idx = pick_r ? r_ext[IDX_W-1:0] : l_ext[IDX_W-1:0];

  assign top_plus_margin = {1'b0, top_r} + {1'b0, margin_r};

  // Sequencer: sift up on insert, sift down on top replace, then report.
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    fill_nxt      = fill_r;
    deg_nxt       = deg_r;
    mc_nxt        = mc_r;
    limit_nxt     = limit_r;
    out_valid_nxt = out_valid_r;
    out_limit_nxt = out_limit_r;
    out_chg_nxt   = out_chg_r;
    out_cnt_nxt   = out_cnt_r;
    ram_we        = 1'b0;
    ram_waddr     = pos_r;
    ram_wdata     = deg_r;
    ram_raddr_a   = parent;
    ram_raddr_b   = r_ext[IDX_W-1:0];

    if (out_ch.valid && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cfg_init_we) begin
      limit_nxt = sat_one(pwdata[DEGREE_W-1:0]);
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          deg_nxt = in_sat;
          if (fill_r < k_cnt) begin
            pos_nxt   = fill_r[IDX_W-1:0];
            fill_nxt  = fill_r + CNT_W'(1);
            mc_nxt    = (fill_r + CNT_W'(1)) == k_cnt;
            state_nxt = S_UP_RD;
          end else if ((fill_r != '0) && (top_r > in_sat)) begin
            pos_nxt   = '0;
            mc_nxt    = 1'b1;
            state_nxt = S_DN_RD;
          end else begin
            mc_nxt    = 1'b0;
            state_nxt = S_FIN;
          end
        end
      end
      S_UP_RD: begin
        if (pos_r == '0) begin
          ram_we    = 1'b1;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        ram_we = 1'b1;
        if (ram_rdata_a >= deg_r) begin
          state_nxt = S_FIN;
        end else begin
          ram_wdata = ram_rdata_a;
          pos_nxt   = parent;
          state_nxt = S_UP_RD;
        end
      end
      S_DN_RD: begin
        ram_raddr_a = l_ext[IDX_W-1:0];
        if (l_ext >= fill_ext) begin
          ram_we    = 1'b1;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        ram_we = 1'b1;
        if (big_val <= deg_r) begin
          state_nxt = S_FIN;
        end else begin
          ram_wdata = big_val;
          pos_nxt   = big_idx;
          state_nxt = S_DN_RD;
        end
      end
      S_FIN: begin
        if (!out_valid_nxt) begin
          out_chg_nxt = 1'b0;
          if (mc_r && (top_plus_margin < {1'b0, limit_r})) begin
            limit_nxt   = top_r;
            out_chg_nxt = 1'b1;
          end
          out_limit_nxt = limit_nxt;
          out_cnt_nxt   = fill_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      limit_r     <= ONE_Q16;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Item payload and working registers.
  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    deg_r       <= deg_nxt;
    mc_r        <= mc_nxt;
    out_limit_r <= out_limit_nxt;
    out_chg_r   <= out_chg_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  // Copy of the heap root, kept in step with every write to entry zero.
  always_ff @(posedge clk) begin
    if (ram_we && (ram_waddr == '0)) begin
      top_r <= ram_wdata;
    end
  end

  tkslt_ram #(
    .WIDTH (DEGREE_W),
    .DEPTH (MAX_KEPT)
  ) u_heap_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .rdata_a (ram_rdata_a),
    .raddr_b (ram_raddr_b),
    .rdata_b (ram_rdata_b)
  );

  // Channel outputs.
  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.limit         = out_limit_r;
  assign out_ch.limit_changed = out_chg_r;
  assign out_ch.held_count    = out_cnt_r;

  // The heap never holds more entries than it has room for.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(MAX_KEPT) >= fill_r)
    else $error("heap fill exceeds depth");

  // The fill only grows, one entry at a time.
  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (fill_r != $past(fill_r))) |-> (fill_r == $past(fill_r) + CNT_W'(1)))
    else $error("heap fill changed by other than one");

  // The limit rises only through a write of the initial limit.
  a_limit_rise: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (limit_r > $past(limit_r))) |-> $past(cfg_init_we))
    else $error("limit rose without a configuration write");

  // Heap writes stay inside the occupied part of the heap.
  a_write_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (LW'(ram_waddr) < fill_ext))
    else $error("heap write beyond fill");

endmodule

/* rtl/core/tkslt_ram.sv */
// ----------------------------------------------------------------------------
// Top-k smallest limit tracker RAM
// Generic synchronous RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module tkslt_ram
  import tkslt_pkg::*;
  #(
    parameter int unsigned WIDTH = DEGREE_W,
    parameter int unsigned DEPTH = MAX_KEPT_DEF,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
  ) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
  );

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read ports.
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
